@@ src/aba_pkg.sv @@
// Shared types, codes and defaults for the aligned bump heap allocator.
package aba_pkg;

    localparam int MAX_ENTRIES_DEF  = 64;
    localparam int HEADER_BYTES_DEF = 28;
    localparam int PAGE_BYTES_DEF   = 4096;

    // Widest dividend: heap_base + used_bytes + header fits in 34 bits.
    localparam int DIVIDEND_W = 34;

    localparam logic CFG_HEAP_BASE    = 1'b0;
    localparam logic CFG_REGION_BYTES = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REGION    = 3'd1,
        ST_FULL      = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_CONTIG    = 3'd5,
        ST_ZEROALIGN = 3'd6
    } t_status;

    typedef struct packed {
        logic        mode;
        logic        contiguous_request;
        logic [31:0] alignment;
        logic [31:0] request_bytes;
        logic [31:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] payload_address;
        logic [20:0] pages_added;
        logic [31:0] used_end;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [31:0]           divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] remainder;
    } t_div_rsp;

    // One allocation record: payload offset, total length, released flag.
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] len;
        logic        released;
    } t_entry;

endpackage

@@ src/aba_divu.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module aba_divu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aba_pkg::t_div_req i_req,
    output aba_pkg::t_div_rsp o_rsp
);
    localparam int DW    = aba_pkg::DIVIDEND_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [31:0]      r_rem;
    logic [31:0]      r_div;

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

@@ src/aba_table.sv @@
// Allocation record memory: one write port, one registered read port.
module aba_table #(
    parameter int ENTRIES = aba_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  aba_pkg::t_entry i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output aba_pkg::t_entry o_rdata
);
    aba_pkg::t_entry r_mem [ENTRIES];
    aba_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/aligned_bump_heap_allocator.sv @@
// Aligned bump heap allocator: one request at a time, results after a multi-cycle sequence.
// An allocate waits on the alignment remainder from the bit-serial divider (load, one
// quotient bit per dividend bit, done), and the page ceilings are shifts by the page size.
// Requests rejected at the first check go straight to the result. A free compares records
// in turn, marks the match, looks at the next record when the match is not the last one,
// and examines tail records while popping; an unknown address is compared against every
// live record. Record reads go through the single registered read port of the record
// memory. Output stalls hold the result. Input stall is high from acceptance until the
// result is transferred; configuration writes are taken only while the block is idle.
module aligned_bump_heap_allocator #(
    parameter int MAX_ENTRIES  = aba_pkg::MAX_ENTRIES_DEF,
    parameter int HEADER_BYTES = aba_pkg::HEADER_BYTES_DEF,
    parameter int PAGE_BYTES   = aba_pkg::PAGE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  aba_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output aba_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int DW    = aba_pkg::DIVIDEND_W;
    localparam int PG_SH = $clog2(PAGE_BYTES);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_WAIT_PAD, S_END, S_REGION,
        S_COMMIT, S_FRD, S_FCMP, S_FMARK, S_FNXT_RD, S_FNXT_CHK, S_POP_RD,
        S_POP_CHK, S_DONE
    } t_state;

    t_state             r_state;
    aba_pkg::t_in_item  r_item;
    logic [31:0]        r_heap_base;
    logic [31:0]        r_region_bytes;
    logic [CNT_W-1:0]   r_live;
    logic [31:0]        r_used;
    logic [31:0]        r_mapped;
    logic [31:0]        r_pad;
    logic [34:0]        r_new_end;
    logic               r_grow;
    logic [CNT_W-1:0]   r_scan;
    logic [IDX_W-1:0]   r_idx;
    aba_pkg::t_entry    r_ent;
    logic [2:0]         r_res_status;
    logic [31:0]        r_res_addr;
    logic [20:0]        r_res_pages;
    logic               r_out_valid;
    aba_pkg::t_div_req  r_div_req;

    aba_pkg::t_div_rsp  w_div_rsp;
    aba_pkg::t_entry    w_rdata;
    aba_pkg::t_entry    w_wdata;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [IDX_W-1:0]   w_raddr;
    logic [CNT_W-1:0]   w_live_m1;
    logic [31:0]        w_rel;
    logic [32:0]        w_region_end;
    logic [32:0]        w_limit;
    logic [35:0]        w_alloc_end;
    logic [31:0]        w_pad;
    logic [31:0]        w_offset;
    logic [31:0]        w_len;
    logic [DW-1:0]      w_pg_new;
    logic [DW-1:0]      w_pg_old;

    aba_divu u_divu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    aba_table #(
        .ENTRIES (MAX_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_live_m1    = r_live - 1'b1;
        w_rel        = r_item.free_address - r_heap_base;
        w_region_end = {1'b0, r_heap_base} + {1'b0, r_region_bytes};
        w_limit      = w_region_end[32] ? 33'h0FFFFFFFF : w_region_end;
        w_alloc_end  = {4'b0, r_heap_base} + {1'b0, r_new_end};
        w_pad        = (w_div_rsp.remainder == '0) ? '0
                       : r_item.alignment - w_div_rsp.remainder;
        w_offset     = r_used + r_pad + 32'(HEADER_BYTES);
        w_len        = r_pad + 32'(HEADER_BYTES) + r_item.request_bytes;
        // page ceilings of the new and the old high-water mark
        w_pg_new     = (DW'(r_heap_base) + DW'(r_new_end[31:0]) + DW'(PAGE_BYTES - 1))
                       >> PG_SH;
        w_pg_old     = (DW'(r_heap_base) + DW'(r_mapped) + DW'(PAGE_BYTES - 1)) >> PG_SH;

        case (r_state)
            S_FNXT_RD: w_raddr = r_idx + 1'b1;
            S_POP_RD:  w_raddr = w_live_m1[IDX_W-1:0];
            default:   w_raddr = r_scan[IDX_W-1:0];
        endcase

        w_we    = 1'b0;
        w_waddr = r_live[IDX_W-1:0];
        w_wdata = {w_offset, w_len, 1'b0};
        case (r_state)
            S_COMMIT: w_we = 1'b1;
            S_FMARK: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = {r_ent.offset, r_ent.len, 1'b1};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_heap_base    <= '0;
            r_region_bytes <= '0;
            r_live         <= '0;
            r_used         <= '0;
            r_mapped       <= '0;
            r_out_valid    <= 1'b0;
            r_div_req      <= '0;
        end else begin
            r_div_req.start <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == aba_pkg::CFG_HEAP_BASE) begin
                    r_heap_base <= i_cfg_data;
                end else begin
                    r_region_bytes <= i_cfg_data;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_addr  <= '0;
                    r_res_pages <= '0;
                    r_scan      <= '0;
                    if (r_item.mode) begin
                        if (r_item.free_address < r_heap_base
                                || {1'b0, r_item.free_address} >= w_region_end) begin
                            r_res_status <= aba_pkg::ST_OUTSIDE;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_FRD;
                        end
                    end else if (r_item.contiguous_request) begin
                        r_res_status <= aba_pkg::ST_CONTIG;
                        r_state      <= S_DONE;
                    end else if (r_item.alignment == '0) begin
                        r_res_status <= aba_pkg::ST_ZEROALIGN;
                        r_state      <= S_DONE;
                    end else if (r_live >= CNT_W'(MAX_ENTRIES)) begin
                        r_res_status <= aba_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= DW'(r_heap_base) + DW'(r_used)
                                              + DW'(HEADER_BYTES);
                        r_div_req.divisor  <= r_item.alignment;
                        r_state            <= S_WAIT_PAD;
                    end
                end
                S_WAIT_PAD: begin
                    if (w_div_rsp.done) begin
                        r_pad   <= w_pad;
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    r_new_end <= {3'b0, r_used} + {3'b0, r_pad} + 35'(HEADER_BYTES)
                                 + {3'b0, r_item.request_bytes};
                    r_state   <= S_REGION;
                end
                S_REGION: begin
                    r_grow <= ({3'b0, r_mapped} < r_new_end);
                    if (w_alloc_end > {3'b0, w_limit}) begin
                        r_res_status <= aba_pkg::ST_REGION;
                        r_state      <= S_DONE;
                    end else if ({3'b0, r_mapped} < r_new_end) begin
                        r_res_pages <= 21'(w_pg_new - w_pg_old);
                        r_state     <= S_COMMIT;
                    end else begin
                        r_res_pages <= '0;
                        r_state     <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (r_grow) begin
                        r_mapped <= r_new_end[31:0];
                    end
                    r_live       <= r_live + 1'b1;
                    r_used       <= r_new_end[31:0];
                    r_res_addr   <= r_heap_base + w_offset;
                    r_res_status <= aba_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                S_FRD: begin
                    if (r_scan == r_live) begin
                        r_res_status <= aba_pkg::ST_UNKNOWN;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_FCMP;
                    end
                end
                S_FCMP: begin
                    if (w_rdata.offset == w_rel) begin
                        r_idx   <= r_scan[IDX_W-1:0];
                        r_ent   <= w_rdata;
                        r_state <= S_FMARK;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_FMARK: begin
                    r_res_status <= aba_pkg::ST_OK;
                    // last record: pop now; otherwise look at the next one
                    if (CNT_W'(r_idx) + 1'b1 == r_live) begin
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_FNXT_RD;
                    end
                end
                S_FNXT_RD: r_state <= S_FNXT_CHK;
                S_FNXT_CHK: begin
                    r_state <= w_rdata.released ? S_POP_RD : S_DONE;
                end
                S_POP_RD: begin
                    r_state <= (r_live == '0) ? S_DONE : S_POP_CHK;
                end
                S_POP_CHK: begin
                    if (w_rdata.released) begin
                        r_used  <= r_used - w_rdata.len;
                        r_live  <= w_live_m1;
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end else if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall                 = (r_state != S_IDLE);
    assign o_cfg_ready                = (r_state == S_IDLE);
    assign o_out_valid                = r_out_valid;
    assign o_out_item.status          = r_res_status;
    assign o_out_item.payload_address = r_res_addr;
    assign o_out_item.pages_added     = r_res_pages;
    assign o_out_item.used_end        = r_used;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(MAX_ENTRIES))
        else $error("record count past capacity");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != aba_pkg::ST_OK)
            |-> (o_out_item.payload_address == '0 && o_out_item.pages_added == '0))
        else $error("error result carries address or pages");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted a second request while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item.used_end))
        else $error("used size moved under a held result");

endmodule
